// ===== hw/rtl/cow_snapshot_block_map_defines.svh =====
// Assertion macros for the copy-on-write block map checker.
`ifndef COW_SNAPSHOT_BLOCK_MAP_DEFINES_SVH
`define COW_SNAPSHOT_BLOCK_MAP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define COWBM_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define COWBM_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cowbm_pkg.sv =====
// Constants, codes and item types of the copy-on-write block map.
package cowbm_pkg;

    localparam int PTRS_PER_MAP = 64;
    localparam int DIR_ENTRIES  = 16;
    localparam int PHYS_BLOCKS  = 1024;

    localparam int OP_W   = 2;
    localparam int LB_W   = 10;
    localparam int BLK_W  = 10;
    localparam int CNT_W  = 11;
    localparam int ST_W   = 2;

    localparam int SLOT_W     = $clog2(PTRS_PER_MAP);
    localparam int ROW_W      = $clog2(PHYS_BLOCKS);
    localparam int ADDR_W     = ROW_W + SLOT_W;
    localparam int LEAF_DEPTH = PHYS_BLOCKS * PTRS_PER_MAP;
    localparam int DIDX_W     = LB_W - SLOT_W;
    localparam int DIR_W      = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_SNAP  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CNT_W-1:0] VOL_RESET = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [LB_W-1:0] logical_block;
    } t_in_item;

    typedef struct packed {
        logic [BLK_W-1:0] phys_block;
        logic             mapped;
        logic             copy_needed;
        logic [BLK_W-1:0] copy_source;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] blocks_in_use;
    } t_out_item;

    typedef struct packed {
        logic             en;
        logic [DIR_W-1:0] idx;
        logic [BLK_W-1:0] blk;
    } t_dir_wr;

    typedef struct packed {
        logic      done;
        t_out_item item;
    } t_seq_res;

endpackage

// ===== hw/rtl/cowbm_dir.sv =====
// Directory of leaf map blocks, cleared by reset, one read and one write port.
module cowbm_dir (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cowbm_pkg::DIR_W-1:0]  i_rd_idx,
    output logic [cowbm_pkg::BLK_W-1:0]  o_rd_blk,
    input  cowbm_pkg::t_dir_wr           i_wr
);
    import cowbm_pkg::*;

    logic [BLK_W-1:0] r_dir [DIR_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIR_ENTRIES; i++) begin
                r_dir[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_dir[i_wr.idx] <= i_wr.blk;
        end
    end

    assign o_rd_blk = r_dir[i_rd_idx];

endmodule

// ===== hw/rtl/cowbm_seq.sv =====
// Lookup and allocation sequencer with the leaf map store.
module cowbm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  cowbm_pkg::t_in_item          i_item,
    input  logic [cowbm_pkg::CNT_W-1:0]  i_volume_blocks,
    output logic                         o_busy,
    output cowbm_pkg::t_seq_res          o_res,
    output logic [cowbm_pkg::DIR_W-1:0]  o_dir_idx,
    input  logic [cowbm_pkg::BLK_W-1:0]  i_dir_blk,
    output cowbm_pkg::t_dir_wr           o_dir_wr
);
    import cowbm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_MAP   = 3'd4;

    // Leaf map store: PTRS_PER_MAP pointers per physical block.
    logic [BLK_W-1:0] mem [LEAF_DEPTH];
    logic [BLK_W-1:0] r_q;

    logic [2:0]        r_state, n_state;
    logic [BLK_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]  r_next, n_next;
    logic [CNT_W-1:0]  r_in_use, n_in_use;
    logic              r_wr, n_wr;
    logic [LB_W-1:0]   r_lb, n_lb;
    logic [BLK_W-1:0]  r_mblk, n_mblk;
    logic [BLK_W-1:0]  r_src, n_src;
    logic [BLK_W-1:0]  r_p, n_p;
    logic [SLOT_W:0]   r_cnt, n_cnt;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BLK_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [DIDX_W-1:0] in_d;
    logic              in_bad;
    logic [CNT_W:0]    snap_sum;
    logic [CNT_W:0]    wr_sum;
    logic [BLK_W-1:0]  p_cur;
    logic              leaf_cow;
    logic [SLOT_W:0]   cnt_prev;
    logic [SLOT_W-1:0] lb_slot;

    assign in_d      = i_item.logical_block[LB_W-1:SLOT_W];
    assign in_bad    = ({1'b0, i_item.logical_block} >= i_volume_blocks)
                       || (int'(in_d) >= DIR_ENTRIES);
    assign o_dir_idx = in_d[DIR_W-1:0];
    assign snap_sum  = {1'b0, r_next} + (CNT_W+1)'(1);
    assign p_cur     = (r_mblk != '0) ? r_q : '0;
    assign leaf_cow  = (r_mblk != '0) && (r_mblk < r_base);
    assign wr_sum    = {1'b0, r_next} + ((r_mblk == '0 || leaf_cow) ?
                       (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign cnt_prev  = r_cnt - 1'b1;
    assign lb_slot   = r_lb[SLOT_W-1:0];
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_next   = r_next;
        n_in_use = r_in_use;
        n_wr     = r_wr;
        n_lb     = r_lb;
        n_mblk   = r_mblk;
        n_src    = r_src;
        n_p      = r_p;
        n_cnt    = r_cnt;
        o_res    = '0;
        o_res.item.blocks_in_use = r_in_use;
        o_dir_wr  = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = {i_dir_blk[ROW_W-1:0], i_item.logical_block[SLOT_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_item.operation)
                        OP_SNAP: begin
                            o_res.done = 1'b1;
                            if (snap_sum > (CNT_W+1)'(PHYS_BLOCKS)) begin
                                o_res.item.status = ST_FULL;
                            end else begin
                                n_base = r_next[BLK_W-1:0];
                                n_next = r_next + 1'b1;
                                o_res.item.phys_block = r_next[BLK_W-1:0];
                                o_res.item.mapped     = 1'b1;
                            end
                        end
                        OP_NONE: begin
                            o_res.done = 1'b1;
                        end
                        default: begin
                            if (in_bad) begin
                                o_res.done        = 1'b1;
                                o_res.item.status = ST_RANGE;
                            end else begin
                                n_wr    = (i_item.operation == OP_WRITE);
                                n_lb    = i_item.logical_block;
                                n_mblk  = i_dir_blk;
                                n_state = S_EVAL;
                            end
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (!r_wr) begin
                    o_res.done = 1'b1;
                    if (p_cur != '0) begin
                        o_res.item.phys_block = p_cur;
                        o_res.item.mapped     = 1'b1;
                    end
                end else if (r_mblk != '0 && p_cur != '0 && p_cur >= r_base) begin
                    o_res.done = 1'b1;
                    o_res.item.phys_block = p_cur;
                    o_res.item.mapped     = 1'b1;
                end else if (wr_sum > (CNT_W+1)'(PHYS_BLOCKS)) begin
                    o_res.done        = 1'b1;
                    o_res.item.status = ST_FULL;
                end else begin
                    n_p   = p_cur;
                    n_cnt = '0;
                    if (r_mblk == '0 || leaf_cow) begin
                        // Take a fresh leaf map and repoint the directory to it.
                        o_dir_wr.en  = 1'b1;
                        o_dir_wr.idx = r_lb[SLOT_W +: DIR_W];
                        o_dir_wr.blk = r_next[BLK_W-1:0];
                        n_src   = r_mblk;
                        n_mblk  = r_next[BLK_W-1:0];
                        n_next  = r_next + 1'b1;
                        n_state = (r_mblk == '0) ? S_CLEAR : S_COPY;
                    end else begin
                        n_state = S_MAP;
                    end
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_mblk[ROW_W-1:0], r_cnt[SLOT_W-1:0]};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == (SLOT_W+1)'(PTRS_PER_MAP - 1)) begin
                    n_state = S_MAP;
                end
            end
            S_COPY: begin
                // Read entry cnt of the old map, write entry cnt-1 of the new one.
                mem_raddr = {r_src[ROW_W-1:0], r_cnt[SLOT_W-1:0]};
                if (r_cnt != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_mblk[ROW_W-1:0], cnt_prev[SLOT_W-1:0]};
                    mem_wdata = r_q;
                end
                if (r_cnt == (SLOT_W+1)'(PTRS_PER_MAP)) begin
                    n_state = S_MAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAP: begin
                n_in_use  = r_in_use + ((r_p == '0) ? (CNT_W)'(1) : '0);
                mem_we    = 1'b1;
                mem_waddr = {r_mblk[ROW_W-1:0], lb_slot};
                mem_wdata = r_next[BLK_W-1:0];
                n_next    = r_next + 1'b1;
                n_state   = S_IDLE;
                o_res.done = 1'b1;
                o_res.item.phys_block    = r_next[BLK_W-1:0];
                o_res.item.mapped        = 1'b1;
                o_res.item.copy_needed   = (r_p != '0);
                o_res.item.copy_source   = r_p;
                o_res.item.blocks_in_use = n_in_use;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_q <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_next   <= (CNT_W)'(1);
            r_in_use <= (CNT_W)'(1);
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_next   <= n_next;
            r_in_use <= n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr   <= n_wr;
        r_lb   <= n_lb;
        r_mblk <= n_mblk;
        r_src  <= n_src;
        r_p    <= n_p;
        r_cnt  <= n_cnt;
    end

endmodule

// ===== hw/rtl/cow_snapshot_block_map.sv =====
// Top level of the two-level copy-on-write block map.
// Path from accept to o_done (registered): snapshot, unused code or out of range end at accept;
// reads and owned writes in S_EVAL; with a data block allocated or copied, S_EVAL and S_MAP;
// a new leaf map adds S_CLEAR before S_MAP, a leaf copy adds S_COPY. One item at a time:
// the next start is taken at the edge that ends the o_done cycle. Results cannot be stalled.
// Synchronous active-low reset clears directory, counters and volume size (1024), not leaves.
module cow_snapshot_block_map (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cowbm_pkg::t_in_item          i_item,
    output logic                         o_done,
    output cowbm_pkg::t_out_item         o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cowbm_pkg::CNT_W-1:0]  i_cfg_data
);
    import cowbm_pkg::*;

    logic [CNT_W-1:0] r_volume_blocks;
    logic             r_done;
    t_out_item        r_result;

    logic             accept;
    logic             seq_busy;
    t_seq_res         seq_res;
    logic [DIR_W-1:0] dir_idx;
    logic [BLK_W-1:0] dir_blk;
    t_dir_wr          dir_wr;

    // Take a new item only while the sequencer stands idle.
    assign accept      = start && !seq_busy;
    assign busy        = seq_busy;
    // Accept the size register whenever no item is in flight.
    assign o_cfg_ready = !seq_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_blocks <= VOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_volume_blocks <= i_cfg_data;
        end
    end

    cowbm_dir u_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (dir_idx),
        .o_rd_blk (dir_blk),
        .i_wr     (dir_wr)
    );

    cowbm_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (accept),
        .i_item          (i_item),
        .i_volume_blocks (r_volume_blocks),
        .o_busy          (seq_busy),
        .o_res           (seq_res),
        .o_dir_idx       (dir_idx),
        .i_dir_blk       (dir_blk),
        .o_dir_wr        (dir_wr)
    );

    // Hold each finished item in the output register for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= seq_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= seq_res.item;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/cowbm_checker.sv =====
// Port-level checks of the copy-on-write block map, bound to the top level.
`include "cow_snapshot_block_map_defines.svh"

module cowbm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input cowbm_pkg::t_out_item  o_result
);
    import cowbm_pkg::*;

    `COWBM_AST_NXT(a_accept_progress, start && !busy, busy || o_done,
                   "accepted item neither busy nor done")
    `COWBM_AST_IMP(a_busy_end_done, $fell(busy), o_done, "busy fell without a result")
    `COWBM_AST_IMP(a_unmapped_zero, o_done && !o_result.mapped,
                   o_result.phys_block == '0 && !o_result.copy_needed,
                   "unmapped result carries a block")
    `COWBM_AST_IMP(a_nocopy_zero, o_done && !o_result.copy_needed,
                   o_result.copy_source == '0, "copy source without copy")
    `COWBM_AST_IMP(a_err_unmapped, o_done && o_result.status != ST_OK,
                   !o_result.mapped, "error result is mapped")

endmodule

bind cow_snapshot_block_map cowbm_checker u_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the copy-on-write block map: directed table, then random items.
module tb_top;
    import cowbm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    // Slowest item is a leaf copy after the longest sender gap, plus the drain and pause before
    // a volume write; allow many times that.
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int CFG_PAUSE     = 8;
    localparam int SUB_ITEMS     = 117;
    localparam int FULL_WANTED   = 24;
    localparam int IDLE_PCT [3]  = '{21, 46, 0};

    typedef enum logic {ROW_ITEM, ROW_VOL} t_row_kind;

    // One row of the directed plan: either an item or a volume write.
    typedef struct packed {
        t_row_kind        kind;
        logic [OP_W-1:0]  op;
        logic [LB_W-1:0]  lb;
        logic [CNT_W-1:0] vol;
        logic             pinned;
        t_out_item        want;
    } t_plan_row;

    // Hand-written result that overrides the predictor for one item.
    typedef struct packed {
        logic      pinned;
        t_out_item want;
    } t_pin;

    // By the range rows blocks_in_use stands at 5: four data blocks mapped on top of the
    // reset count of one.
    localparam t_plan_row DIRECTED [27] = '{
        '{ROW_VOL,  OP_READ,  10'd0,    11'd1024, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd0,    11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_OK, 11'd1}},
        '{ROW_ITEM, OP_READ,  10'd1023, 11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_OK, 11'd1}},
        '{ROW_ITEM, OP_NONE,  10'd1023, 11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_OK, 11'd1}},
        '{ROW_ITEM, OP_WRITE, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd1023, 11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd1022, 11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_SNAP,  10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd1023, 11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd1,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd1023, 11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd1022, 11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_SNAP,  10'd1023, 11'd0, 1'b0, '0},
        '{ROW_VOL,  OP_READ,  10'd0,    11'd64, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd63,   11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_WRITE, 10'd64,   11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_RANGE, 11'd5}},
        '{ROW_ITEM, OP_READ,  10'd1023, 11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_RANGE, 11'd5}},
        '{ROW_VOL,  OP_READ,  10'd0,    11'd0, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd0,    11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_RANGE, 11'd5}},
        '{ROW_ITEM, OP_WRITE, 10'd0,    11'd0, 1'b1, '{10'd0, 1'b0, 1'b0, 10'd0, ST_RANGE, 11'd5}},
        '{ROW_ITEM, OP_SNAP,  10'd0,    11'd0, 1'b0, '0},
        '{ROW_VOL,  OP_READ,  10'd0,    11'd1024, 1'b0, '0},
        '{ROW_ITEM, OP_READ,  10'd1023, 11'd0, 1'b0, '0}
    };

    // Drive every input to a known value from time zero.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    t_in_item         i_item      = '0;
    logic             i_cfg_valid = 1'b0;
    logic [CNT_W-1:0] i_cfg_data  = '0;
    logic             busy;
    logic             o_done;
    t_out_item        o_result;
    logic             o_cfg_ready;

    // Shadow copy of the map state, advanced once per accepted item and on each volume write.
    logic [BLK_W-1:0] dir_ptr  [DIR_ENTRIES];
    logic [BLK_W-1:0] leaf_ptr [LEAF_DEPTH];
    logic [BLK_W-1:0] base_blk;
    logic [CNT_W-1:0] free_blk;
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] vol_blocks;

    t_out_item        outcome_q [$];
    t_pin             pinned_q  [$];
    bit [LB_W-1:0]    recent    [8];
    int               mismatch_cnt = 0;
    int               full_cnt     = 0;
    int               stall_cnt    = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    cow_snapshot_block_map DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Work out the result of one item and advance the shadow state.
    function automatic t_out_item cow_outcome(t_in_item it);
        t_out_item        res;
        int unsigned      dix;
        int unsigned      slot;
        logic [BLK_W-1:0] leaf;
        logic [BLK_W-1:0] dat;
        logic [BLK_W-1:0] fresh;
        logic             leaf_shared;
        int               need;
        res  = '0;
        dix  = it.logical_block / PTRS_PER_MAP;
        slot = it.logical_block % PTRS_PER_MAP;
        if (it.operation == OP_SNAP) begin
            // Move the base up to the next free block and reserve it.
            if (int'(free_blk) + 1 > PHYS_BLOCKS) begin
                res.status = ST_FULL;
            end else begin
                base_blk       = free_blk[BLK_W-1:0];
                free_blk       = free_blk + 1'b1;
                res.phys_block = base_blk;
                res.mapped     = 1'b1;
            end
        end else if (it.operation != OP_NONE) begin
            if (it.logical_block >= vol_blocks || dix >= DIR_ENTRIES) begin
                res.status = ST_RANGE;
            end else begin
                leaf = dir_ptr[dix];
                dat  = (leaf != '0) ? leaf_ptr[int'(leaf) * PTRS_PER_MAP + slot] : '0;
                if (it.operation == OP_READ) begin
                    if (dat != '0) begin
                        res.phys_block = dat;
                        res.mapped     = 1'b1;
                    end
                end else if (leaf != '0 && dat != '0 && dat >= base_blk) begin
                    // Data block already owned by the active volume: no allocation.
                    res.phys_block = dat;
                    res.mapped     = 1'b1;
                end else begin
                    leaf_shared = (leaf != '0) && (leaf < base_blk);
                    need        = (leaf == '0 || leaf_shared) ? 2 : 1;
                    if (int'(free_blk) + need > PHYS_BLOCKS) begin
                        // All or nothing: leave every counter untouched.
                        res.status = ST_FULL;
                    end else begin
                        if (leaf == '0) begin
                            leaf         = free_blk[BLK_W-1:0];
                            free_blk     = free_blk + 1'b1;
                            dir_ptr[dix] = leaf;
                            for (int s = 0; s < PTRS_PER_MAP; s++)
                                leaf_ptr[int'(leaf) * PTRS_PER_MAP + s] = '0;
                        end else if (leaf_shared) begin
                            fresh    = free_blk[BLK_W-1:0];
                            free_blk = free_blk + 1'b1;
                            for (int s = 0; s < PTRS_PER_MAP; s++)
                                leaf_ptr[int'(fresh) * PTRS_PER_MAP + s] =
                                    leaf_ptr[int'(leaf) * PTRS_PER_MAP + s];
                            dir_ptr[dix] = fresh;
                            leaf         = fresh;
                        end
                        if (dat != '0) begin
                            res.copy_needed = 1'b1;
                            res.copy_source = dat;
                        end else begin
                            used_cnt = used_cnt + 1'b1;
                        end
                        dat      = free_blk[BLK_W-1:0];
                        free_blk = free_blk + 1'b1;
                        leaf_ptr[int'(leaf) * PTRS_PER_MAP + slot] = dat;
                        res.phys_block = dat;
                        res.mapped     = 1'b1;
                    end
                end
            end
        end
        res.blocks_in_use = used_cnt;
        return res;
    endfunction

    // Draw one random item. Lean on writes and snapshots while block use lags
    // a schedule that runs out of space around item 600, so the full case is reached.
    function automatic t_in_item pick_item(int k);
        t_in_item it;
        int       roll;
        int       w_pct;
        int       s_pct;
        logic     heavy;
        heavy = int'(free_blk) * 600 < k * PHYS_BLOCKS;
        w_pct = heavy ? 78 : 28;
        s_pct = heavy ? 12 : 3;
        roll  = $urandom_range(99);
        if (roll < 2)
            it.operation = OP_NONE;
        else if (roll < 2 + s_pct)
            it.operation = OP_SNAP;
        else if (roll < 2 + s_pct + w_pct)
            it.operation = OP_WRITE;
        else
            it.operation = OP_READ;
        roll = $urandom_range(99);
        if (roll < 45) begin
            it.logical_block = LB_W'($urandom_range(1023));
        end else if (roll < 80) begin
            it.logical_block = recent[$urandom_range(7)];
        end else begin
            // Edges of the block number and of the current volume size.
            case ($urandom_range(3))
                0: it.logical_block = '0;
                1: it.logical_block = '1;
                2: it.logical_block = LB_W'(vol_blocks - 1'b1);
                default: it.logical_block = LB_W'(vol_blocks);
            endcase
        end
        if (it.operation == OP_WRITE)
            recent[$urandom_range(7)] = it.logical_block;
        return it;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_cnt++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Hold start low until every outstanding item has produced its result.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (outcome_q.size() != 0);
    endtask

    // Offer one item, after a random gap when the idle roll says so.
    task automatic send_item(t_in_item it, logic pinned, t_out_item want, int idle_pct);
        t_pin pin;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            // Mostly short gaps, now and then one long enough to span a leaf walk.
            repeat (($urandom_range(7) == 0) ? $urandom_range(80, 4) : $urandom_range(3, 1))
                @(posedge i_clk);
        end
        pin.pinned = pinned;
        pin.want   = want;
        pinned_q.push_back(pin);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Write the volume size only once the block has gone quiet.
    task automatic write_volume(logic [CNT_W-1:0] v);
        wait_drained();
        repeat (CFG_PAUSE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // Sample both handshakes on the rising edge: predict on accept, check on strobe.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item predicted;
        t_pin      pin;
        logic      moved;
        if (!i_rst_n) begin
            for (int d = 0; d < DIR_ENTRIES; d++)
                dir_ptr[d] = '0;
            base_blk   = '0;
            free_blk   = CNT_W'(1);
            used_cnt   = CNT_W'(1);
            vol_blocks = VOL_RESET;
            stall_cnt  = 0;
        end else begin
            moved = 1'b0;
            // Check the result first, so a strobe on the accepting edge cannot match.
            if (o_done === 1'b1) begin
                moved = 1'b1;
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result with no item outstanding");
                end else begin
                    want = outcome_q.pop_front();
                    check_field("phys_block", 32'(o_result.phys_block),
                                32'(want.phys_block));
                    check_field("mapped", 32'(o_result.mapped), 32'(want.mapped));
                    check_field("copy_needed", 32'(o_result.copy_needed),
                                32'(want.copy_needed));
                    check_field("copy_source", 32'(o_result.copy_source),
                                32'(want.copy_source));
                    check_field("status", 32'(o_result.status), 32'(want.status));
                    check_field("blocks_in_use", 32'(o_result.blocks_in_use),
                                32'(want.blocks_in_use));
                end
            end else if (o_done !== 1'b0) begin
                flag_mismatch("result strobe unknown");
            end
            if (i_cfg_valid && o_cfg_ready) begin
                vol_blocks = i_cfg_data;
                moved      = 1'b1;
            end
            if (start && !busy) begin
                pin       = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
                predicted = cow_outcome(i_item);
                if (predicted.status == ST_FULL)
                    full_cnt++;
                outcome_q.push_back(pin.pinned ? pin.want : predicted);
                moved = 1'b1;
            end
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        t_in_item         row_item;
        logic [CNT_W-1:0] vol;
        int               k;
        int               n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan under light sender idling.
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_VOL) begin
                write_volume(DIRECTED[r].vol);
            end else begin
                row_item.operation     = DIRECTED[r].op;
                row_item.logical_block = DIRECTED[r].lb;
                send_item(row_item, DIRECTED[r].pinned, DIRECTED[r].want, IDLE_PCT[0]);
            end
        end

        // Random part: three idling modes, each split by a volume write.
        // Stretch the last stretch a little until running out of space has been seen enough.
        k = 0;
        for (int m = 0; m < 3; m++) begin
            for (int sub = 0; sub < 2; sub++) begin
                case (m * 2 + sub)
                    0: vol = CNT_W'(1024);
                    1: vol = CNT_W'($urandom_range(1023, 512));
                    2: vol = CNT_W'(1023);
                    3: vol = CNT_W'($urandom_range(1024, 1));
                    4: vol = CNT_W'($urandom_range(1024, 256));
                    default: vol = CNT_W'(1024);
                endcase
                write_volume(vol);
                n = 0;
                while (n < SUB_ITEMS || (m == 2 && sub == 1 && full_cnt < FULL_WANTED
                                         && n < SUB_ITEMS + SUB_ITEMS / 2)) begin
                    // Now and then hold off until the block has caught up completely.
                    if ($urandom_range(99) < 2)
                        wait_drained();
                    send_item(pick_item(k), 1'b0, '0, IDLE_PCT[m]);
                    n++;
                    k++;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== cow_snapshot_block_map.f =====
+incdir+hw/rtl
hw/rtl/cowbm_pkg.sv
hw/rtl/cowbm_dir.sv
hw/rtl/cowbm_seq.sv
hw/rtl/cow_snapshot_block_map.sv
hw/rtl/cowbm_checker.sv
test/tb_top.sv
